FILE: rtl/four_bit_mcu_execute_unit_core_macros.svh
// Assertion macros for the execute unit.
`ifndef FOUR_BIT_MCU_EXECUTE_UNIT_CORE_MACROS_SVH
`define FOUR_BIT_MCU_EXECUTE_UNIT_CORE_MACROS_SVH

`ifndef SYNTH
`define FBMCU_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("implication check failed");
`define FBMCU_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle check failed");
`else
`define FBMCU_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define FBMCU_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

FILE: rtl/fbmcu_pkg.sv
package fbmcu_pkg;

    typedef enum logic [5:0] {
        CMD_TAY = 6'd0, CMD_TYA, CMD_CLA, CMD_TAM, CMD_TAMIY, CMD_TAMZA, CMD_TMY,
        CMD_TMA, CMD_XMA, CMD_AMAAC, CMD_SAMAN, CMD_IMAC, CMD_DMAN, CMD_IA,
        CMD_IYC, CMD_DAN, CMD_DYN, CMD_A6AAC, CMD_A8AAC, CMD_A10AAC, CMD_CPAIZ,
        CMD_ALEM, CMD_ALEC, CMD_MNEZ, CMD_YNEA, CMD_YNEC, CMD_SBIT, CMD_RBIT,
        CMD_TBIT, CMD_TCY, CMD_TCMIY, CMD_KNEZ, CMD_TKA, CMD_SETR, CMD_RSTR,
        CMD_TDO, CMD_CLO, CMD_LDX, CMD_COMX, CMD_LDP, CMD_BR, CMD_CALL, CMD_RETN
    } t_cmd;

    typedef struct packed {
        logic [3:0]  acc;
        logic [3:0]  y;
        logic [1:0]  x;
        logic        st;
        logic        sl;
        logic [3:0]  pa;
        logic [3:0]  pb;
        logic [5:0]  pc;
        logic [5:0]  sr;
        logic        cl;
        logic [10:0] r;
        logic [4:0]  o;
    } t_state;

    typedef struct packed {
        logic       we;
        logic [3:0] data;
    } t_ram_wr;

    localparam t_state STATE_RESET = '{
        acc: 4'd10, y: 4'd10, x: 2'd2, st: 1'b0, sl: 1'b0, pa: 4'd15, pb: 4'd15,
        pc: 6'd0, sr: 6'd0, cl: 1'b0, r: 11'd0, o: 5'd0
    };

    localparam logic [3:0] RAM_RESET = 4'd10;
    localparam logic [3:0] Y_R_LIMIT = 4'd10;

endpackage

FILE: rtl/four_bit_mcu_execute_unit_core.sv
// Pipeline: the input register, then the result register; a result stall holds the item
// in the input register and blocks new input until the result is taken.
// Throughput: one instruction per cycle unless the output stalls; the data RAM read for the next
// instruction is issued from the next-state X:Y in the same cycle, with write-to-read bypass.
// Reset: synchronous, active low; restores the machine state and valid flags, clears the RAM
// valid bits (unwritten words read as 10), no clearing pass, ready as soon as reset is released.
`include "four_bit_mcu_execute_unit_core_macros.svh"

module four_bit_mcu_execute_unit_core #(
    parameter int RAM_WORDS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [5:0]  i_command,
    input  logic [5:0]  i_operand,
    input  logic [3:0]  i_k_lines,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_next_pc,
    output logic [3:0]  o_page,
    output logic [10:0] o_r_lines,
    output logic [4:0]  o_o_lines,
    output logic        o_status,
    output logic [3:0]  o_acc_value
);
    import fbmcu_pkg::*;

    localparam int AW         = $clog2(RAM_WORDS);
    localparam int WRAP_STEPS = 63 / RAM_WORDS;

    function automatic logic [AW-1:0] f_wrap(input logic [5:0] a);
        logic [6:0] v;
        v = {1'b0, a};
        for (int i = 0; i < WRAP_STEPS; i++) begin
            if (v >= 7'(RAM_WORDS)) begin
                v = v - 7'(RAM_WORDS);
            end
        end
        return v[AW-1:0];
    endfunction

    logic             r_in_valid;
    logic [5:0]       r_cmd;
    logic [5:0]       r_operand;
    logic [3:0]       r_k;
    logic             r_out_valid;
    t_state           r_state;
    t_state           n_state;
    t_state           ex_state;
    t_ram_wr          ex_wr;
    logic             w_exec;
    logic [AW-1:0]    w_wr_addr;
    logic [AW-1:0]    w_rd_addr;
    logic [3:0]       r_mem [RAM_WORDS];
    logic [RAM_WORDS-1:0] r_mem_valid;
    logic [3:0]       r_rd_data;
    logic [5:0]       r_out_pc;
    logic [3:0]       r_out_page;
    logic [10:0]      r_out_r;
    logic [4:0]       r_out_o;
    logic             r_out_st;
    logic [3:0]       r_out_acc;

    assign w_exec     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_exec;
    assign n_state    = w_exec ? ex_state : r_state;
    assign w_wr_addr  = f_wrap({r_state.x, r_state.y});
    assign w_rd_addr  = f_wrap({n_state.x, n_state.y});

    fbmcu_exec u_exec (
        .i_state    (r_state),
        .i_command  (r_cmd),
        .i_operand  (r_operand),
        .i_k_lines  (r_k),
        .i_ram_data (r_rd_data),
        .o_state    (ex_state),
        .o_ram_wr   (ex_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd     <= i_command;
            r_operand <= i_operand;
            r_k       <= i_k_lines;
        end
        if (w_exec) begin
            r_out_pc   <= ex_state.pc;
            r_out_page <= ex_state.pa;
            r_out_r    <= ex_state.r;
            r_out_o    <= ex_state.o;
            r_out_st   <= ex_state.st;
            r_out_acc  <= ex_state.acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec && ex_wr.we) begin
            r_mem[w_wr_addr] <= ex_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_valid <= '0;
        end else if (w_exec && ex_wr.we) begin
            r_mem_valid[w_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_data <= RAM_RESET;
        end else if (w_exec && ex_wr.we && (w_wr_addr == w_rd_addr)) begin
            r_rd_data <= ex_wr.data;
        end else if (r_mem_valid[w_rd_addr]) begin
            r_rd_data <= r_mem[w_rd_addr];
        end else begin
            r_rd_data <= RAM_RESET;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_next_pc   = r_out_pc;
    assign o_page      = r_out_page;
    assign o_r_lines   = r_out_r;
    assign o_o_lines   = r_out_o;
    assign o_status    = r_out_st;
    assign o_acc_value = r_out_acc;

    `FBMCU_ASSERT_NEXT(a_exec_gives_result, i_clk, i_rst_n, w_exec, o_out_valid)
    `FBMCU_ASSERT_NEXT(a_held_item_kept, i_clk, i_rst_n, r_in_valid && !w_exec, r_in_valid)
    `FBMCU_ASSERT_NEXT(a_pc_only_on_exec, i_clk, i_rst_n, !w_exec, $stable(r_state.pc))
    `FBMCU_ASSERT_NEXT(a_call_sets_latch, i_clk, i_rst_n, w_exec && r_state.st && (r_cmd == CMD_CALL), r_state.cl)

endmodule

FILE: rtl/fbmcu_exec.sv
module fbmcu_exec (
    input  fbmcu_pkg::t_state  i_state,
    input  logic [5:0]         i_command,
    input  logic [5:0]         i_operand,
    input  logic [3:0]         i_k_lines,
    input  logic [3:0]         i_ram_data,
    output fbmcu_pkg::t_state  o_state,
    output fbmcu_pkg::t_ram_wr o_ram_wr
);
    import fbmcu_pkg::*;

    logic [3:0] c_val;
    logic [1:0] b_num;
    logic [3:0] b_mask;
    logic [3:0] m;

    assign c_val  = {i_operand[0], i_operand[1], i_operand[2], i_operand[3]};
    assign b_num  = {i_operand[0], i_operand[1]};
    assign b_mask = 4'b0001 << b_num;
    assign m      = i_ram_data;

    always_comb begin
        logic [4:0] sum;
        logic       loaded;
        o_state  = i_state;
        o_ram_wr = '0;
        loaded   = 1'b0;
        sum      = '0;
        case (i_command)
            CMD_TAY: begin
                o_state.y  = i_state.acc;
                o_state.st = 1'b1;
            end
            CMD_TYA: begin
                o_state.acc = i_state.y;
                o_state.st  = 1'b1;
            end
            CMD_CLA: begin
                o_state.acc = 4'd0;
                o_state.st  = 1'b1;
            end
            CMD_TAM: begin
                o_ram_wr   = '{we: 1'b1, data: i_state.acc};
                o_state.st = 1'b1;
            end
            CMD_TAMIY: begin
                o_ram_wr   = '{we: 1'b1, data: i_state.acc};
                o_state.y  = i_state.y + 4'd1;
                o_state.st = 1'b1;
            end
            CMD_TAMZA: begin
                o_ram_wr    = '{we: 1'b1, data: i_state.acc};
                o_state.acc = 4'd0;
                o_state.st  = 1'b1;
            end
            CMD_TMY: begin
                o_state.y  = m;
                o_state.st = 1'b1;
            end
            CMD_TMA: begin
                o_state.acc = m;
                o_state.st  = 1'b1;
            end
            CMD_XMA: begin
                o_ram_wr    = '{we: 1'b1, data: i_state.acc};
                o_state.acc = m;
                o_state.st  = 1'b1;
            end
            CMD_AMAAC, CMD_IMAC, CMD_DMAN, CMD_DAN, CMD_A6AAC, CMD_A8AAC,
            CMD_A10AAC: begin
                case (i_command)
                    CMD_AMAAC: sum = {1'b0, i_state.acc} + {1'b0, m};
                    CMD_IMAC:  sum = {1'b0, m} + 5'd1;
                    CMD_DMAN:  sum = {1'b0, m} + 5'd15;
                    CMD_DAN:   sum = {1'b0, i_state.acc} + 5'd15;
                    CMD_A6AAC: sum = {1'b0, i_state.acc} + 5'd6;
                    CMD_A8AAC: sum = {1'b0, i_state.acc} + 5'd8;
                    default:   sum = {1'b0, i_state.acc} + 5'd10;
                endcase
                o_state.acc = sum[3:0];
                o_state.st  = sum[4];
            end
            CMD_SAMAN, CMD_CPAIZ: begin
                sum = {1'b0, ~i_state.acc} + 5'd1
                    + ((i_command == CMD_SAMAN) ? {1'b0, m} : 5'd0);
                o_state.acc = sum[3:0];
                o_state.st  = sum[4];
            end
            CMD_IA: begin
                o_state.acc = i_state.acc + 4'd1;
                o_state.st  = 1'b1;
            end
            CMD_IYC, CMD_DYN: begin
                sum = {1'b0, i_state.y} + ((i_command == CMD_IYC) ? 5'd1 : 5'd15);
                o_state.y  = sum[3:0];
                o_state.st = sum[4];
            end
            CMD_ALEM: begin
                sum        = {1'b0, ~i_state.acc} + {1'b0, m} + 5'd1;
                o_state.st = sum[4];
            end
            CMD_ALEC: begin
                sum        = {1'b0, ~i_state.acc} + {1'b0, c_val} + 5'd1;
                o_state.st = sum[4];
            end
            CMD_MNEZ: o_state.st = (m != 4'd0);
            CMD_YNEA: begin
                o_state.st = (i_state.acc != i_state.y);
                o_state.sl = (i_state.acc != i_state.y);
            end
            CMD_YNEC: o_state.st = (i_state.y != c_val);
            CMD_SBIT: begin
                o_ram_wr   = '{we: 1'b1, data: m | b_mask};
                o_state.st = 1'b1;
            end
            CMD_RBIT: begin
                o_ram_wr   = '{we: 1'b1, data: m & ~b_mask};
                o_state.st = 1'b1;
            end
            CMD_TBIT: o_state.st = |(m & b_mask);
            CMD_TCY: begin
                o_state.y  = c_val;
                o_state.st = 1'b1;
            end
            CMD_TCMIY: begin
                o_ram_wr   = '{we: 1'b1, data: c_val};
                o_state.y  = i_state.y + 4'd1;
                o_state.st = 1'b1;
            end
            CMD_KNEZ: o_state.st = (i_k_lines != 4'd0);
            CMD_TKA: begin
                o_state.acc = i_k_lines;
                o_state.st  = 1'b1;
            end
            CMD_SETR: begin
                if (i_state.y <= Y_R_LIMIT) begin
                    o_state.r = i_state.r | (11'd1 << i_state.y);
                end
                o_state.st = 1'b1;
            end
            CMD_RSTR: begin
                if (i_state.y <= Y_R_LIMIT) begin
                    o_state.r = i_state.r & ~(11'd1 << i_state.y);
                end
                o_state.st = 1'b1;
            end
            CMD_TDO: begin
                o_state.o  = {i_state.acc, i_state.sl};
                o_state.st = 1'b1;
            end
            CMD_CLO: begin
                o_state.o  = 5'd0;
                o_state.st = 1'b1;
            end
            CMD_LDX: begin
                o_state.x  = b_num;
                o_state.st = 1'b1;
            end
            CMD_COMX: begin
                o_state.x  = ~i_state.x;
                o_state.st = 1'b1;
            end
            CMD_LDP: begin
                o_state.pb = c_val;
                o_state.st = 1'b1;
            end
            CMD_BR: begin
                if (i_state.st) begin
                    o_state.pc = i_operand;
                    loaded     = 1'b1;
                    if (!i_state.cl) begin
                        o_state.pa = i_state.pb;
                    end
                end
                o_state.st = 1'b1;
            end
            CMD_CALL: begin
                if (i_state.st) begin
                    o_state.pc = i_operand;
                    o_state.pb = i_state.pa;
                    loaded     = 1'b1;
                    if (!i_state.cl) begin
                        o_state.sr = i_state.pc + 6'd1;
                        o_state.pa = i_state.pb;
                        o_state.cl = 1'b1;
                    end
                end
                o_state.st = 1'b1;
            end
            CMD_RETN: begin
                if (i_state.cl) begin
                    o_state.pc = i_state.sr;
                    o_state.cl = 1'b0;
                    loaded     = 1'b1;
                end
                o_state.pa = i_state.pb;
                o_state.st = 1'b1;
            end
            default: begin
            end
        endcase
        if (!loaded) begin
            o_state.pc = i_state.pc + 6'd1;
        end
    end

endmodule

FILE: tb/sv/tb_four_bit_mcu_execute_unit_core.sv
`timescale 1ns / 100ps

module tb_four_bit_mcu_execute_unit_core;
    import fbmcu_pkg::*;

    typedef struct packed {
        logic [5:0]  pc;
        logic [3:0]  page;
        logic [10:0] r;
        logic [4:0]  o;
        logic        st;
        logic [3:0]  acc;
    } t_exec_result;

    typedef struct packed {
        logic [5:0]   cmd;
        logic [5:0]   opnd;
        logic [3:0]   k;
        bit           typed;
        t_exec_result want;
    } t_stim_row;

    localparam int RANDOM_ITEMS = 900;
    localparam int NUM_PHASES   = 5;
    localparam int MAX_PRINTS   = 40;

    localparam logic [5:0] CMD_UNUSED_FIRST = 6'd43;
    localparam logic [5:0] CMD_UNUSED_LAST  = 6'd63;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [5:0]  i_command = '0;
    logic [5:0]  i_operand = '0;
    logic [3:0]  i_k_lines = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [5:0]  o_next_pc;
    logic [3:0]  o_page;
    logic [10:0] o_r_lines;
    logic [4:0]  o_o_lines;
    logic        o_status;
    logic [3:0]  o_acc_value;

    // machine state mirror
    t_state       arch;
    logic [3:0]   ram_img [64];

    t_exec_result pending_results[$];
    t_stim_row    directed_rows[$];
    int           err_count = 0;
    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;

    four_bit_mcu_execute_unit_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_operand   (i_operand),
        .i_k_lines   (i_k_lines),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_next_pc   (o_next_pc),
        .o_page      (o_page),
        .o_r_lines   (o_r_lines),
        .o_o_lines   (o_o_lines),
        .o_status    (o_status),
        .o_acc_value (o_acc_value)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_exec_result exec_instruction(input logic [5:0] cmd,
                                                      input logic [5:0] opnd,
                                                      input logic [3:0] k);
        logic [3:0]   cval;
        logic [1:0]   bnum;
        logic [5:0]   addr;
        logic [3:0]   mval;
        logic [4:0]   sum;
        logic [3:0]   tmp;
        logic         jumped;
        t_exec_result res;
        cval   = {opnd[0], opnd[1], opnd[2], opnd[3]};
        bnum   = {opnd[0], opnd[1]};
        addr   = {arch.x, arch.y};
        mval   = ram_img[addr];
        jumped = 1'b0;
        case (cmd)
            CMD_TAY: begin
                arch.y = arch.acc;
                arch.st = 1'b1;
            end
            CMD_TYA: begin
                arch.acc = arch.y;
                arch.st = 1'b1;
            end
            CMD_CLA: begin
                arch.acc = 4'd0;
                arch.st = 1'b1;
            end
            CMD_TAM: begin
                ram_img[addr] = arch.acc;
                arch.st = 1'b1;
            end
            CMD_TAMIY: begin
                ram_img[addr] = arch.acc;
                arch.y = arch.y + 4'd1;
                arch.st = 1'b1;
            end
            CMD_TAMZA: begin
                ram_img[addr] = arch.acc;
                arch.acc = 4'd0;
                arch.st = 1'b1;
            end
            CMD_TMY: begin
                arch.y = mval;
                arch.st = 1'b1;
            end
            CMD_TMA: begin
                arch.acc = mval;
                arch.st = 1'b1;
            end
            CMD_XMA: begin
                ram_img[addr] = arch.acc;
                arch.acc = mval;
                arch.st = 1'b1;
            end
            CMD_AMAAC, CMD_DAN, CMD_A6AAC, CMD_A8AAC, CMD_A10AAC: begin
                case (cmd)
                    CMD_AMAAC: tmp = mval;
                    CMD_DAN:   tmp = 4'd15;
                    CMD_A6AAC: tmp = 4'd6;
                    CMD_A8AAC: tmp = 4'd8;
                    default:   tmp = 4'd10;
                endcase
                sum = {1'b0, arch.acc} + {1'b0, tmp};
                arch.st = sum[4];
                arch.acc = sum[3:0];
            end
            CMD_SAMAN, CMD_CPAIZ: begin
                tmp = (cmd == CMD_SAMAN) ? mval : 4'd0;
                sum = {1'b0, ~arch.acc} + {1'b0, tmp} + 5'd1;
                arch.st = sum[4];
                arch.acc = sum[3:0];
            end
            CMD_IMAC, CMD_DMAN: begin
                tmp = (cmd == CMD_IMAC) ? 4'd1 : 4'd15;
                sum = {1'b0, mval} + {1'b0, tmp};
                arch.st = sum[4];
                arch.acc = sum[3:0];
            end
            CMD_IA: begin
                arch.acc = arch.acc + 4'd1;
                arch.st = 1'b1;
            end
            CMD_IYC, CMD_DYN: begin
                tmp = (cmd == CMD_IYC) ? 4'd1 : 4'd15;
                sum = {1'b0, arch.y} + {1'b0, tmp};
                arch.st = sum[4];
                arch.y = sum[3:0];
            end
            CMD_ALEM, CMD_ALEC: begin
                tmp = (cmd == CMD_ALEM) ? mval : cval;
                sum = {1'b0, ~arch.acc} + {1'b0, tmp} + 5'd1;
                arch.st = sum[4];
            end
            CMD_MNEZ: arch.st = (mval != 4'd0);
            CMD_YNEA: begin
                arch.st = (arch.acc != arch.y);
                arch.sl = arch.st;
            end
            CMD_YNEC: arch.st = (arch.y != cval);
            CMD_SBIT: begin
                ram_img[addr] = mval | (4'b0001 << bnum);
                arch.st = 1'b1;
            end
            CMD_RBIT: begin
                ram_img[addr] = mval & ~(4'b0001 << bnum);
                arch.st = 1'b1;
            end
            CMD_TBIT: arch.st = mval[bnum];
            CMD_TCY: begin
                arch.y = cval;
                arch.st = 1'b1;
            end
            CMD_TCMIY: begin
                ram_img[addr] = cval;
                arch.y = arch.y + 4'd1;
                arch.st = 1'b1;
            end
            CMD_KNEZ: arch.st = (k != 4'd0);
            CMD_TKA: begin
                arch.acc = k;
                arch.st = 1'b1;
            end
            CMD_SETR: begin
                if (arch.y <= Y_R_LIMIT) begin
                    arch.r[arch.y] = 1'b1;
                end
                arch.st = 1'b1;
            end
            CMD_RSTR: begin
                if (arch.y <= Y_R_LIMIT) begin
                    arch.r[arch.y] = 1'b0;
                end
                arch.st = 1'b1;
            end
            CMD_TDO: begin
                arch.o = {arch.acc, arch.sl};
                arch.st = 1'b1;
            end
            CMD_CLO: begin
                arch.o = 5'd0;
                arch.st = 1'b1;
            end
            CMD_LDX: begin
                arch.x = bnum;
                arch.st = 1'b1;
            end
            CMD_COMX: begin
                arch.x = ~arch.x;
                arch.st = 1'b1;
            end
            CMD_LDP: begin
                arch.pb = cval;
                arch.st = 1'b1;
            end
            CMD_BR: begin
                if (arch.st) begin
                    arch.pc = opnd;
                    jumped = 1'b1;
                    if (!arch.cl) begin
                        arch.pa = arch.pb;
                    end
                end
                arch.st = 1'b1;
            end
            CMD_CALL: begin
                if (arch.st && !arch.cl) begin
                    arch.sr = arch.pc + 6'd1;
                    tmp = arch.pb;
                    arch.pb = arch.pa;
                    arch.pa = tmp;
                    arch.pc = opnd;
                    arch.cl = 1'b1;
                    jumped = 1'b1;
                end else if (arch.st) begin
                    arch.pc = opnd;
                    arch.pb = arch.pa;
                    jumped = 1'b1;
                end
                arch.st = 1'b1;
            end
            CMD_RETN: begin
                if (arch.cl) begin
                    arch.pc = arch.sr;
                    arch.cl = 1'b0;
                    jumped = 1'b1;
                end
                arch.pa = arch.pb;
                arch.st = 1'b1;
            end
            default: ;
        endcase
        if (!jumped) begin
            arch.pc = arch.pc + 6'd1;
        end
        res = '{arch.pc, arch.pa, arch.r, arch.o, arch.st, arch.acc};
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTS) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
        err_count++;
    endtask

    task automatic check_result();
        t_exec_result want;
        if (pending_results.size() == 0) begin
            flag_mismatch("unexpected transaction", 1, 0);
        end else begin
            want = pending_results.pop_front();
            if (o_next_pc !== want.pc) flag_mismatch("next_pc", o_next_pc, want.pc);
            if (o_page !== want.page) flag_mismatch("page", o_page, want.page);
            if (o_r_lines !== want.r) flag_mismatch("r_lines", o_r_lines, want.r);
            if (o_o_lines !== want.o) flag_mismatch("o_lines", o_o_lines, want.o);
            if (o_status !== want.st) flag_mismatch("status", o_status, want.st);
            if (o_acc_value !== want.acc) flag_mismatch("acc_value", o_acc_value, want.acc);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_result();
        end
        i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic send_instruction(input logic [5:0] cmd, input logic [5:0] opnd,
                                    input logic [3:0] k, input bit typed,
                                    input t_exec_result want);
        int           gap;
        t_exec_result pred;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_operand  <= opnd;
        i_k_lines  <= k;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = exec_instruction(cmd, opnd, k);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic stim_row(input logic [5:0] cmd, input logic [5:0] opnd,
                            input logic [3:0] k, input bit typed = 1'b0,
                            input t_exec_result want = '0);
        directed_rows.push_back('{cmd, opnd, k, typed, want});
    endtask

    initial begin : stimulus
        int         tx_pct [NUM_PHASES];
        int         rx_pct [NUM_PHASES];
        int         per_phase;
        logic [5:0] cmd;
        t_stim_row  row;

        tx_pct = '{0, 57, 0, 16, 0};
        rx_pct = '{0, 0, 57, 16, 0};
        per_phase = RANDOM_ITEMS / NUM_PHASES;

        arch = STATE_RESET;
        foreach (ram_img[i]) ram_img[i] = RAM_RESET;

        // from reset: TDO shows A=10, CLA, DAN without carry,
        // BR not taken, CALL to 63, PC wrap, RETN with and without call latch
        stim_row(CMD_TDO,  6'd0,  4'd0, 1, '{6'd1,  4'd15, 11'd0, 5'd20, 1'b1, 4'd10});
        stim_row(CMD_CLA,  6'd0,  4'd0, 1, '{6'd2,  4'd15, 11'd0, 5'd20, 1'b1, 4'd0});
        stim_row(CMD_DAN,  6'd0,  4'd0, 1, '{6'd3,  4'd15, 11'd0, 5'd20, 1'b0, 4'd15});
        stim_row(CMD_BR,   6'h15, 4'd0, 1, '{6'd4,  4'd15, 11'd0, 5'd20, 1'b1, 4'd15});
        stim_row(CMD_CALL, 6'h3F, 4'd0, 1, '{6'd63, 4'd15, 11'd0, 5'd20, 1'b1, 4'd15});
        stim_row(CMD_IA,   6'd0,  4'd0, 1, '{6'd0,  4'd15, 11'd0, 5'd20, 1'b1, 4'd0});
        stim_row(CMD_RETN, 6'd0,  4'd0, 1, '{6'd5,  4'd15, 11'd0, 5'd20, 1'b1, 4'd0});
        stim_row(CMD_RETN, 6'd0,  4'd0, 1, '{6'd6,  4'd15, 11'd0, 5'd20, 1'b1, 4'd0});
        stim_row(CMD_KNEZ,  6'd0,  4'd0);
        stim_row(CMD_KNEZ,  6'd0,  4'd15);
        stim_row(CMD_TKA,   6'd0,  4'd15);
        stim_row(CMD_A6AAC, 6'd0,  4'd0);
        stim_row(CMD_A8AAC, 6'd0,  4'd0);
        stim_row(CMD_A10AAC, 6'd0, 4'd0);
        stim_row(CMD_TCY,   6'h0F, 4'd0);
        stim_row(CMD_SETR,  6'd0,  4'd0);
        stim_row(CMD_RSTR,  6'd0,  4'd0);
        stim_row(CMD_TCY,   6'h05, 4'd0);
        stim_row(CMD_SETR,  6'd0,  4'd0);
        stim_row(CMD_TCY,   6'h00, 4'd0);
        stim_row(CMD_SETR,  6'd0,  4'd0);
        stim_row(CMD_RSTR,  6'd0,  4'd0);
        stim_row(CMD_LDX,   6'h03, 4'd0);
        stim_row(CMD_TAMIY, 6'd0,  4'd0);
        stim_row(CMD_TAM,   6'd0,  4'd0);
        stim_row(CMD_TAMZA, 6'd0,  4'd0);
        stim_row(CMD_TMY,   6'd0,  4'd0);
        stim_row(CMD_TMA,   6'd0,  4'd0);
        stim_row(CMD_XMA,   6'd0,  4'd0);
        stim_row(CMD_AMAAC, 6'd0,  4'd0);
        stim_row(CMD_SAMAN, 6'd0,  4'd0);
        stim_row(CMD_IMAC,  6'd0,  4'd0);
        stim_row(CMD_DMAN,  6'd0,  4'd0);
        stim_row(CMD_CPAIZ, 6'd0,  4'd0);
        stim_row(CMD_ALEM,  6'd0,  4'd0);
        stim_row(CMD_ALEC,  6'h3F, 4'd0);
        stim_row(CMD_ALEC,  6'h00, 4'd0);
        stim_row(CMD_MNEZ,  6'd0,  4'd0);
        stim_row(CMD_YNEA,  6'd0,  4'd0);
        stim_row(CMD_YNEC,  6'h2A, 4'd0);
        stim_row(CMD_SBIT,  6'h03, 4'd0);
        stim_row(CMD_SBIT,  6'h00, 4'd0);
        stim_row(CMD_RBIT,  6'h01, 4'd0);
        stim_row(CMD_TBIT,  6'h02, 4'd0);
        stim_row(CMD_TAY,   6'd0,  4'd0);
        stim_row(CMD_TYA,   6'd0,  4'd0);
        stim_row(CMD_IYC,   6'd0,  4'd0);
        stim_row(CMD_DYN,   6'd0,  4'd0);
        stim_row(CMD_TDO,   6'd0,  4'd0);
        stim_row(CMD_CLO,   6'd0,  4'd0);
        stim_row(CMD_COMX,  6'd0,  4'd0);
        stim_row(CMD_LDP,   6'h00, 4'd0);
        stim_row(CMD_TCMIY, 6'h3F, 4'd0);
        stim_row(CMD_BR,    6'h2A, 4'd0);
        stim_row(CMD_CALL,  6'h11, 4'd0);
        stim_row(CMD_CALL,  6'h22, 4'd0);
        stim_row(CMD_RETN,  6'd0,  4'd0);
        stim_row(CMD_UNUSED_LAST,  6'h3F, 4'd15);
        stim_row(CMD_UNUSED_FIRST, 6'd0,  4'd0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_instruction(row.cmd, row.opnd, row.k, row.typed, row.want);
        end
        wait_for_results();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            tx_idle_pct  = tx_pct[ph];
            rx_stall_pct = rx_pct[ph];
            for (int n = 0; n < per_phase; n++) begin
                if ($urandom_range(15) == 0) begin
                    cmd = 6'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
                end else begin
                    cmd = 6'($urandom_range(CMD_RETN, CMD_TAY));
                end
                send_instruction(cmd, 6'($urandom_range(63)), 4'($urandom_range(15)),
                                 1'b0, '0);
            end
            // hold off until everything in flight has drained
            wait_for_results();
        end

        rx_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            flag_mismatch("missing transactions", 0, pending_results.size());
        end
        if (err_count == 0) begin
            $display("** four_bit_mcu_execute_unit_core: PASSED **");
        end else begin
            $display("** four_bit_mcu_execute_unit_core: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("** four_bit_mcu_execute_unit_core: FAILED **");
        $finish;
    end

endmodule

FILE: four_bit_mcu_execute_unit_core.f
+incdir+rtl
rtl/fbmcu_pkg.sv
rtl/fbmcu_exec.sv
rtl/four_bit_mcu_execute_unit_core.sv
tb/sv/tb_four_bit_mcu_execute_unit_core.sv
